### rtl/epm_pkg.sv
// epm_pkg: shared types and constants of the exact pattern matcher
// no dependencies; imported by the interfaces, the output queue and the top level
`default_nettype none

package epm_pkg;

    // smallest pattern length in use
    localparam int MIN_LEN = 2;

    // field widths fixed by the word formats
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int LEN_W   = 6;
    localparam int POS_W   = 32;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // one result word
    typedef struct packed {
        logic             match;
        logic [POS_W-1:0] end_position;
    } result_t;

endpackage

`default_nettype wire

### rtl/epm_if.sv
// epm_item_if, epm_result_if: valid/ready channels for input items and results
// depends on epm_pkg
`default_nettype none

interface epm_item_if
    import epm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] pattern_index;
    logic               text_start;

    modport source (output valid, output kind, output byte_value,
                    output pattern_index, output text_start, input ready);
    modport sink   (input valid, input kind, input byte_value,
                    input pattern_index, input text_start, output ready);
endinterface

interface epm_result_if
    import epm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             match;
    logic [POS_W-1:0] end_position;

    modport source (output valid, output match, output end_position, input ready);
    modport sink   (input valid, input match, input end_position, output ready);
endinterface

`default_nettype wire

### rtl/epm_out_fifo.sv
// epm_out_fifo: small result queue that decouples the match stage from the sink
// depends on epm_pkg
`default_nettype none

module epm_out_fifo
    import epm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire result_t              push_data,
    input  wire logic                 pop,
    output logic                      head_valid,
    output result_t                   head_data,
    output logic [OUT_CNT_W-1:0]      count
);

    result_t                entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   do_pop;

    // head of queue
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/exact_pattern_matcher.sv
// exact_pattern_matcher: shift-and string matcher over a character mask table
// depends on epm_pkg, epm_if (epm_item_if, epm_result_if) and epm_out_fifo
//
//   channel   dir   handshake            payload
//   item      in    valid/ready          kind, byte_value, pattern_index, text_start
//   result    out   valid/ready          match, end_position
//   config    in    apb write/read       pattern_length at byte address 0
//
// A text byte is taken every cycle while ready is high; its result is queued in
// the following cycle. The rate is set by the single read port of the mask table,
// indexed by the byte. A pattern load reads that port for both the old and the
// new byte rows, so the item channel holds ready low for one cycle after each load.
// After reset a clearing pass writes the 256 table rows, one a cycle, with ready
// low. A stalled result sink backs up into a four-word queue; ready falls once
// queue and match stage can take no more.
`default_nettype none

module exact_pattern_matcher
    import epm_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    epm_item_if.sink                    item,
    epm_result_if.source                result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int ROWS = 1 << BYTE_W;

    // character mask table: bit i of row c set where pattern byte i equals c
    logic [MAX_LEN-1:0]    mask_mem [ROWS];
    logic [MAX_LEN-1:0]    mem_rdata_reg;
    logic [BYTE_W-1:0]     mem_raddr;
    logic [BYTE_W-1:0]     raddr_reg;
    logic                  mem_we;
    logic [BYTE_W-1:0]     mem_waddr;
    logic [MAX_LEN-1:0]    mem_wdata;
    logic [MAX_LEN-1:0]    rd_fix;

    // last write, for read-during-write bypass
    logic                  fwd_valid_reg;
    logic [BYTE_W-1:0]     fwd_addr_reg;
    logic [MAX_LEN-1:0]    fwd_data_reg;

    // clearing pass
    logic                  clear_busy_reg;
    logic [BYTE_W-1:0]     clear_addr_reg;

    // pattern bytes, kept so a load knows which row loses its bit
    logic [BYTE_W-1:0]     pat_reg [MAX_LEN];
    logic [BYTE_W-1:0]     old_byte;

    // load pipeline
    logic                  ld1_valid_reg;
    logic [INDEX_W-1:0]    ld1_idx_reg;
    logic [BYTE_W-1:0]     ld1_old_reg;
    logic [BYTE_W-1:0]     ld1_new_reg;
    logic                  ld2_valid_reg;
    logic [INDEX_W-1:0]    ld2_idx_reg;
    logic [BYTE_W-1:0]     ld2_new_reg;
    logic [MAX_LEN-1:0]    ld1_bit;
    logic [MAX_LEN-1:0]    ld2_bit;

    // match stage
    logic                  s1_valid_reg;
    logic                  s1_start_reg;
    logic [MAX_LEN-1:0]    pm_reg;
    logic [MAX_LEN-1:0]    pm_next;
    logic [MAX_LEN-1:0]    pm_base;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_now;
    logic [POS_W-1:0]      pos_next;
    logic [MAX_LEN-1:0]    len_mask;
    logic [MAX_LEN-1:0]    top_sel;
    result_t               s1_result;

    // configuration
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic                  cfg_write;

    // handshake
    logic                  item_fire;
    logic                  idx_ok;
    logic                  load_go;
    logic                  text_go;
    logic                  pop;
    logic [OUT_CNT_W-1:0]  q_count;
    logic [OUT_CNT_W:0]    q_load;
    result_t               q_head;

    // item acceptance
    assign q_load     = {1'b0, q_count} + {{OUT_CNT_W{1'b0}}, s1_valid_reg};
    assign item.ready = !clear_busy_reg && !ld1_valid_reg
                        && (q_load < (OUT_CNT_W+1)'(OUT_DEPTH));
    assign item_fire  = item.valid && item.ready;
    assign idx_ok     = int'(item.pattern_index) < MAX_LEN;
    assign load_go    = item_fire && (item.kind == KIND_LOAD) && idx_ok;
    assign text_go    = item_fire && (item.kind == KIND_TEXT);

    // old byte at the load index
    always_comb
    begin
        old_byte = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (int'(item.pattern_index) == i)
            begin
                old_byte = pat_reg[i];
            end
        end
    end

    // bit of the loaded position
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            ld1_bit[i] = (int'(ld1_idx_reg) == i);
            ld2_bit[i] = (int'(ld2_idx_reg) == i);
        end
    end

    // table read address
    always_comb
    begin
        if (ld1_valid_reg)
        begin
            mem_raddr = ld1_new_reg;
        end
        else if (item.kind == KIND_LOAD)
        begin
            mem_raddr = old_byte;
        end
        else
        begin
            mem_raddr = item.byte_value;
        end
    end

    // read data with bypass of the write made in the read cycle
    assign rd_fix = (fwd_valid_reg && (fwd_addr_reg == raddr_reg)) ? fwd_data_reg
                                                                   : mem_rdata_reg;

    // table write: clearing pass, then old row loses the bit, new row gains it
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (clear_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
        end
        else if (ld1_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = ld1_old_reg;
            mem_wdata = rd_fix & ~ld1_bit;
        end
        else if (ld2_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = ld2_new_reg;
            mem_wdata = rd_fix | ld2_bit;
        end
    end

    // mask table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mask_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mask_mem[mem_raddr];
        raddr_reg     <= mem_raddr;
        fwd_addr_reg  <= mem_waddr;
        fwd_data_reg  <= mem_wdata;
    end

    // length masks
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            len_mask[i] = (i < int'(len_reg));
            top_sel[i]  = (i == int'(len_reg) - 1);
        end
    end

    // shift-and update
    always_comb
    begin
        pm_base  = s1_start_reg ? '0 : pm_reg;
        pos_now  = s1_start_reg ? '0 : pos_reg;
        pm_next  = {pm_base[MAX_LEN-2:0], 1'b1} & rd_fix & len_mask;
        pos_next = pos_now + 1'b1;
        s1_result.match        = |(pm_next & top_sel);
        s1_result.end_position = pos_now;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            ld1_valid_reg  <= 1'b0;
            ld2_valid_reg  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            pm_reg         <= '0;
            pos_reg        <= '0;
            len_reg        <= LEN_W'(MIN_LEN);
        end
        else
        begin
            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == BYTE_W'(ROWS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
            fwd_valid_reg <= mem_we;
            ld1_valid_reg <= load_go;
            ld2_valid_reg <= ld1_valid_reg;
            s1_valid_reg  <= text_go;
            if (s1_valid_reg)
            begin
                pm_reg  <= pm_next;
                pos_reg <= pos_next;
            end
            if (cfg_write)
            begin
                len_reg <= len_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            ld1_idx_reg  <= item.pattern_index;
            ld1_old_reg  <= old_byte;
            ld1_new_reg  <= item.byte_value;
            s1_start_reg <= item.text_start;
        end
        if (ld1_valid_reg)
        begin
            ld2_idx_reg <= ld1_idx_reg;
            ld2_new_reg <= ld1_new_reg;
        end
    end

    // pattern bytes, cleared with the table so a first load has a defined old row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (load_go)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                if (int'(item.pattern_index) == i)
                begin
                    pat_reg[i] <= item.byte_value;
                end
            end
        end
    end

    // result queue
    assign pop = result.valid && result.ready;

    epm_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_valid_reg),
        .push_data  (s1_result),
        .pop        (pop),
        .head_valid (result.valid),
        .head_data  (q_head),
        .count      (q_count)
    );

    assign result.match        = q_head.match;
    assign result.end_position = q_head.end_position;

    // configuration port, length clamped into the supported range
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1] == REG_PATTERN_LENGTH);

    always_comb
    begin
        if (pwdata[LEN_W-1:0] < LEN_W'(MIN_LEN))
        begin
            len_next = LEN_W'(MIN_LEN);
        end
        else if (int'(pwdata[LEN_W-1:0]) > MAX_LEN)
        begin
            len_next = LEN_W'(MAX_LEN);
        end
        else
        begin
            len_next = pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[APB_ADDR_W-1] == REG_PATTERN_LENGTH)
        begin
            prdata = {{(APB_DATA_W-LEN_W){1'b0}}, len_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

endmodule

`default_nettype wire
